// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Combinational invariant, sampled on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Temporal property, sampled on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`endif

`endif

// File: rtl/tcwu_pkg.sv
package tcwu_pkg;

  // Field widths
  localparam int SEQ_W   = 24;
  localparam int CWND_W  = 24;
  localparam int SS_W    = 16;
  localparam int WIN_W   = 16;
  localparam int EFF_W   = 25;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * SEQ_W + EFF_W + CWND_W + WIN_W);

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Serial divider: one quotient bit per cycle over the squared segment size
  localparam int DIV_STEPS = 2 * SS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT_SIZE = 3'd0,
    REG_INIT_SEQ     = 3'd1,
    REG_TOTAL_BYTES  = 3'd2,
    REG_INIT_RWIN    = 3'd3,
    REG_INIT_CWND    = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [SS_W-1:0]   SEGMENT_SIZE_RST = 16'd100;
  localparam logic [SEQ_W-1:0]  INIT_SEQ_RST     = 24'd0;
  localparam logic [SEQ_W-1:0]  TOTAL_BYTES_RST  = 24'd2500;
  localparam logic [WIN_W-1:0]  INIT_RWIN_RST    = 16'd2000;
  localparam logic [CWND_W-1:0] INIT_CWND_RST    = 24'd100;

  // Limits
  localparam logic [CWND_W-1:0] CWND_MAX = '1;
  localparam logic [CWND_W-1:0] CWND_MIN = CWND_W'(1);

endpackage

// File: rtl/tcp_congestion_window_update.sv
// Sender-side TCP congestion window tracker (slow start, then congestion
// avoidance). Every input transaction is one round: an ACK number and the
// receiver's advertised window. While the held advertised window is nonzero and
// bytes remain, the block sends the next segment (first/last byte numbers on
// the output) and applies the ACK: progress doubles cwnd, the first stalled ACK
// halves it and enters avoidance for good, later stalled ACKs add MSS*MSS/cwnd.
// Every round returns exactly one result transaction. A round runs through
// S_CALC, S_FIN and S_OUT (S_CALC to S_OUT when nothing can be sent), with
// S_DIV and S_ADD before S_FIN in avoidance with a stalled ACK, where a
// bit-serial restoring divider produces one quotient bit per cycle for the
// 32-bit MSS squared. The next input is taken once the output register holds
// the result. A write to a defined config index restarts the transfer from the registers.
`include "assert_macros.svh"

module tcp_congestion_window_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write port
  input  logic                                 cfg_we,
  input  logic [tcwu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcwu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // ACK stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tcwu_pkg::IN_TDATA_W-1:0]      in_tdata,   // ack_number, receiver_window
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tcwu_pkg::OUT_TDATA_W-1:0]     out_tdata,  // segment_first, segment_last,
                                                           // eff_window,
                                                           // cwnd,
                                                           // advertised_window
  output logic                                 out_tuser   // segment_valid
);

  localparam int SEQ_W  = tcwu_pkg::SEQ_W;
  localparam int CWND_W = tcwu_pkg::CWND_W;
  localparam int SS_W   = tcwu_pkg::SS_W;
  localparam int WIN_W  = tcwu_pkg::WIN_W;
  localparam int EFF_W  = tcwu_pkg::EFF_W;
  localparam int DQ_W   = tcwu_pkg::DIV_STEPS;
  localparam int CNT_W  = tcwu_pkg::DIV_CNT_W;
  localparam int EXT_W  = EFF_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_ADD,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [SS_W-1:0]   ss_r, ss_nxt;
  logic [SEQ_W-1:0]  iseq_r, iseq_nxt;
  logic [SEQ_W-1:0]  total_r, total_nxt;
  logic [WIN_W-1:0]  irwin_r, irwin_nxt;
  logic [CWND_W-1:0] icwnd_r, icwnd_nxt;

  // connection state
  logic [CWND_W-1:0]       cwnd_r, cwnd_nxt;
  logic [SEQ_W-1:0]        nts_r, nts_nxt;
  logic [SEQ_W-1:0]        nua_r, nua_nxt;
  logic [WIN_W-1:0]        adv_r, adv_nxt;
  logic signed [EFF_W-1:0] effh_r, effh_nxt;
  logic                    avoid_r, avoid_nxt;

  // per-round working registers
  logic [SEQ_W-1:0]  ack_r, ack_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [CWND_W-1:0] lim_r, lim_nxt;
  logic              lim_hold_r, lim_hold_nxt;
  logic [CWND_W-1:0] rem_r, rem_nxt;
  logic [DQ_W-1:0]   dq_r, dq_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              seg_valid_r, seg_valid_nxt;
  logic [SEQ_W-1:0]  first_r, first_nxt;
  logic [SEQ_W-1:0]  last_r, last_nxt;

  // output register
  logic                                 out_tvalid_r, out_tvalid_nxt;
  logic [tcwu_pkg::OUT_TDATA_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic                                 out_tuser_r, out_tuser_nxt;

  // combinational helpers
  logic                    can_send;
  logic [SEQ_W-1:0]        last_w;
  logic [CWND_W-1:0]       win_ext;
  logic [CWND_W:0]         cwnd_dbl;
  logic [CWND_W-1:0]       cwnd_half;
  logic [CWND_W:0]         rem_sh;
  logic                    rem_ge;
  logic [DQ_W:0]           cwnd_sum;
  logic [CWND_W-1:0]       lim_fin;
  logic [SEQ_W-1:0]        inflight;
  logic signed [EXT_W-1:0] eff_raw;
  logic signed [EXT_W-1:0] eff_pos_lim;
  logic signed [EXT_W-1:0] eff_neg_lim;
  logic                    load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // round datapath terms
  assign can_send    = (adv_r != '0) && (nts_r < total_r);
  assign last_w      = nts_r + SEQ_W'(ss_r) - SEQ_W'(1);
  assign win_ext     = CWND_W'(win_r);
  assign cwnd_dbl    = {cwnd_r, 1'b0};
  assign cwnd_half   = cwnd_r >> 1;
  assign rem_sh      = {rem_r, dq_r[DQ_W-1]};
  assign rem_ge      = (rem_sh >= {1'b0, cwnd_r});
  assign cwnd_sum    = (DQ_W + 1)'(cwnd_r) + (DQ_W + 1)'(dq_r);
  assign lim_fin     = lim_hold_r ? lim_r : ((cwnd_r < win_ext) ? cwnd_r : win_ext);
  assign inflight    = nts_r - ack_r;
  assign eff_raw     = $signed({2'b00, lim_fin}) - EXT_W'($signed(inflight));
  assign eff_pos_lim = $signed(EXT_W'(tcwu_pkg::CWND_MAX));
  assign eff_neg_lim = -eff_pos_lim;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    ss_nxt         = ss_r;
    iseq_nxt       = iseq_r;
    total_nxt      = total_r;
    irwin_nxt      = irwin_r;
    icwnd_nxt      = icwnd_r;
    cwnd_nxt       = cwnd_r;
    nts_nxt        = nts_r;
    nua_nxt        = nua_r;
    adv_nxt        = adv_r;
    effh_nxt       = effh_r;
    avoid_nxt      = avoid_r;
    ack_nxt        = ack_r;
    win_nxt        = win_r;
    lim_nxt        = lim_r;
    lim_hold_nxt   = lim_hold_r;
    rem_nxt        = rem_r;
    dq_nxt         = dq_r;
    cnt_nxt        = cnt_r;
    seg_valid_nxt  = seg_valid_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    load           = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ack_nxt   = in_tdata[SEQ_W-1:0];
          win_nxt   = in_tdata[SEQ_W+WIN_W-1:SEQ_W];
          state_nxt = S_CALC;
        end
      end

      S_CALC: begin
        if (!can_send) begin
          // nothing to send (window zero or transfer finished): report held values only
          seg_valid_nxt = 1'b0;
          first_nxt     = '0;
          last_nxt      = '0;
          state_nxt     = S_OUT;
        end else begin
          seg_valid_nxt = 1'b1;
          first_nxt     = nts_r;
          last_nxt      = last_w;
          nts_nxt       = last_w + SEQ_W'(1);
          nua_nxt       = ack_r;
          adv_nxt       = win_r;
          lim_hold_nxt  = 1'b0;
          if (ack_r != nua_r) begin
            // progress: limit uses the window before doubling
            lim_nxt      = (cwnd_r < win_ext) ? cwnd_r : win_ext;
            lim_hold_nxt = 1'b1;
            cwnd_nxt     = cwnd_dbl[CWND_W] ? tcwu_pkg::CWND_MAX : cwnd_dbl[CWND_W-1:0];
            state_nxt    = S_FIN;
          end else if (!avoid_r) begin
            avoid_nxt = 1'b1;
            cwnd_nxt  = (cwnd_half == '0) ? tcwu_pkg::CWND_MIN : cwnd_half;
            state_nxt = S_FIN;
          end else begin
            // start serial divide of MSS squared by cwnd
            dq_nxt    = DQ_W'(ss_r) * DQ_W'(ss_r);
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt = rem_ge ? CWND_W'(rem_sh - {1'b0, cwnd_r}) : rem_sh[CWND_W-1:0];
        dq_nxt  = {dq_r[DQ_W-2:0], rem_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DQ_W - 1)) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        cwnd_nxt  = (cwnd_sum[DQ_W:CWND_W] != '0) ? tcwu_pkg::CWND_MAX
                                                  : cwnd_sum[CWND_W-1:0];
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // effective window, clamped to +/- max window
        if (eff_raw > eff_pos_lim) begin
          effh_nxt = EFF_W'(eff_pos_lim);
        end else if (eff_raw < eff_neg_lim) begin
          effh_nxt = EFF_W'(eff_neg_lim);
        end else begin
          effh_nxt = EFF_W'(eff_raw);
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = seg_valid_r;
          out_tdata_nxt  = {{tcwu_pkg::OUT_PAD_W{1'b0}}, adv_r, cwnd_r, effh_r,
                            last_r, first_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // config writes to defined registers restart the transfer
    if (cfg_we) begin
      case (cfg_index)
        tcwu_pkg::REG_SEGMENT_SIZE: begin
          ss_nxt = cfg_wdata[SS_W-1:0];
          load   = 1'b1;
        end
        tcwu_pkg::REG_INIT_SEQ: begin
          iseq_nxt = cfg_wdata[SEQ_W-1:0];
          load     = 1'b1;
        end
        tcwu_pkg::REG_TOTAL_BYTES: begin
          total_nxt = cfg_wdata[SEQ_W-1:0];
          load      = 1'b1;
        end
        tcwu_pkg::REG_INIT_RWIN: begin
          irwin_nxt = cfg_wdata[WIN_W-1:0];
          load      = 1'b1;
        end
        tcwu_pkg::REG_INIT_CWND: begin
          icwnd_nxt = cfg_wdata[CWND_W-1:0];
          load      = 1'b1;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end

    if (load) begin
      cwnd_nxt  = (icwnd_nxt == '0) ? tcwu_pkg::CWND_MIN : icwnd_nxt;
      nts_nxt   = iseq_nxt;
      nua_nxt   = iseq_nxt;
      adv_nxt   = irwin_nxt;
      effh_nxt  = '0;
      avoid_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ss_r         <= tcwu_pkg::SEGMENT_SIZE_RST;
      iseq_r       <= tcwu_pkg::INIT_SEQ_RST;
      total_r      <= tcwu_pkg::TOTAL_BYTES_RST;
      irwin_r      <= tcwu_pkg::INIT_RWIN_RST;
      icwnd_r      <= tcwu_pkg::INIT_CWND_RST;
      cwnd_r       <= tcwu_pkg::INIT_CWND_RST;
      nts_r        <= tcwu_pkg::INIT_SEQ_RST;
      nua_r        <= tcwu_pkg::INIT_SEQ_RST;
      adv_r        <= tcwu_pkg::INIT_RWIN_RST;
      effh_r       <= '0;
      avoid_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ss_r         <= ss_nxt;
      iseq_r       <= iseq_nxt;
      total_r      <= total_nxt;
      irwin_r      <= irwin_nxt;
      icwnd_r      <= icwnd_nxt;
      cwnd_r       <= cwnd_nxt;
      nts_r        <= nts_nxt;
      nua_r        <= nua_nxt;
      adv_r        <= adv_nxt;
      effh_r       <= effh_nxt;
      avoid_r      <= avoid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ack_r       <= ack_nxt;
    win_r       <= win_nxt;
    lim_r       <= lim_nxt;
    lim_hold_r  <= lim_hold_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    cnt_r       <= cnt_nxt;
    seg_valid_r <= seg_valid_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // checks
  `ASSERT_ALWAYS(a_cwnd_nonzero, clk, rst_n, cwnd_r != '0, "cwnd reached zero")
  `ASSERT_PROP(a_avoid_sticky, clk, rst_n, (avoid_r && !cfg_we) |=> avoid_r, "avoidance left without restart")
  `ASSERT_PROP(a_div_rem, clk, rst_n, (state_r == S_DIV && !cfg_we) |=> (rem_r < cwnd_r), "divider remainder not below divisor")
  `ASSERT_PROP(a_accept_calc, clk, rst_n, (in_tvalid && in_tready) |=> (state_r == S_CALC), "accepted ACK not processed")

endmodule
